// File: hw/rtl/stream_reassembly_buffer_macros.svh
// Assertion macros shared by the checker of the stream reassembly buffer.
// No dependencies; included by files that hold concurrent assertions.
`ifndef STREAM_REASSEMBLY_BUFFER_MACROS_SVH
`define STREAM_REASSEMBLY_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/srb_pkg.sv
// Types, codes and helper functions of the stream reassembly buffer.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package srb_pkg;

  localparam int unsigned ROW_BITS = 8;
  localparam int unsigned ROW_LOG  = 3;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_CLR   = 4'd1;
  localparam logic [3:0] OP_SLOT  = 4'd2;
  localparam logic [3:0] OP_SET   = 4'd3;
  localparam logic [3:0] OP_RDAT  = 4'd4;
  localparam logic [3:0] OP_RRD   = 4'd5;
  localparam logic [3:0] OP_RWR   = 4'd6;
  localparam logic [3:0] OP_RFIN  = 4'd7;
  localparam logic [3:0] OP_SINIT = 4'd8;
  localparam logic [3:0] OP_SRD   = 4'd9;
  localparam logic [3:0] OP_SEV   = 4'd10;
  localparam logic [3:0] OP_OUT   = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic       load;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       in_win;
    logic       scan_stop;
    logic       v_last;
    logic       v_init_last;
  } stat_t;

  // Index of the lowest set bit; ROW_BITS when only the top bit is set.
  function automatic logic [ROW_LOG:0] lowest_one(input logic [ROW_BITS:0] x);
    logic [ROW_LOG:0] r;
    r = '0;
    for (int i = ROW_BITS; i >= 0; i--) begin
      if (x[i]) begin
        r = (ROW_LOG + 1)'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/srb_ctrl.sv
// Controller state machine of the stream reassembly buffer.
// Depends on srb_pkg; drives the datapath by operation codes.
`default_nettype none

module srb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic           m_ready_i,
  output logic           m_valid_o,
  input  srb_pkg::stat_t stat_i,
  output srb_pkg::ctrl_t ctrl_o
);
  import srb_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_WSET  = 4'd3;
  localparam logic [3:0] S_RDAT  = 4'd4;
  localparam logic [3:0] S_RMRD  = 4'd5;
  localparam logic [3:0] S_RMWR  = 4'd6;
  localparam logic [3:0] S_RMFIN = 4'd7;
  localparam logic [3:0] S_SINIT = 4'd8;
  localparam logic [3:0] S_SRD   = 4'd9;
  localparam logic [3:0] S_SEV   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic [3:0] op;

  assign s_ready_o   = (state_q == S_IDLE);
  assign m_valid_o   = ovalid_q;
  assign ctrl_o.op   = op;
  assign ctrl_o.load = s_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    op      = OP_NOP;
    case (state_q)
      S_INIT: begin
        op = OP_CLR;
        if (stat_i.v_init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        case (stat_i.cmd)
          CMD_WRITE: begin
            if (stat_i.in_win) begin
              op      = OP_SLOT;
              state_d = S_WSET;
            end else begin
              op      = OP_SINIT;
              state_d = S_SRD;
            end
          end
          CMD_READ: begin
            op      = OP_SLOT;
            state_d = S_RDAT;
          end
          CMD_REMOVE: begin
            op      = OP_SINIT;
            state_d = S_RMRD;
          end
          default: begin
            op      = OP_SINIT;
            state_d = S_SRD;
          end
        endcase
      end
      S_WSET: begin
        op      = OP_SET;
        state_d = S_SINIT;
      end
      S_RDAT: begin
        op      = OP_RDAT;
        state_d = S_SINIT;
      end
      S_RMRD: begin
        op      = OP_RRD;
        state_d = S_RMWR;
      end
      S_RMWR: begin
        op      = OP_RWR;
        state_d = stat_i.v_last ? S_RMFIN : S_RMRD;
      end
      S_RMFIN: begin
        op      = OP_RFIN;
        state_d = S_SINIT;
      end
      S_SINIT: begin
        op      = OP_SINIT;
        state_d = S_SRD;
      end
      S_SRD: begin
        op      = OP_SRD;
        state_d = S_SEV;
      end
      S_SEV: begin
        op      = OP_SEV;
        state_d = stat_i.scan_stop ? S_FIN : S_SRD;
      end
      S_FIN: begin
        if (!ovalid_q || m_ready_i) begin
          op      = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (m_ready_i) ovalid_d = 1'b0;
    if (op == OP_OUT) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/srb_dpath.sv
// Datapath of the stream reassembly buffer: byte store, filled map in rows,
// window registers, run scan and result register. Depends on srb_pkg.
`default_nettype none

module srb_dpath #(
  parameter int unsigned WINDOW_BYTES = 1024,
  localparam int unsigned AW = $clog2(WINDOW_BYTES),
  localparam int unsigned RW = AW - srb_pkg::ROW_LOG,
  localparam int unsigned ROWS = WINDOW_BYTES / srb_pkg::ROW_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srb_pkg::ctrl_t ctrl_i,
  output srb_pkg::stat_t stat_o,
  input  logic [1:0]     in_cmd_i,
  input  logic [31:0]    in_pos_i,
  input  logic [7:0]     in_byte_i,
  input  logic [AW-1:0]  in_ridx_i,
  input  logic [AW:0]    in_rcnt_i,
  output logic [7:0]     out_rdata_o,
  output logic [31:0]    out_off_o,
  output logic [AW:0]    out_len_o,
  output logic           out_drop_o
);
  import srb_pkg::*;

  logic [7:0]          dmem [WINDOW_BYTES];
  logic [ROW_BITS-1:0] fmem [ROWS];

  logic [1:0]          cmd_q;
  logic [31:0]         pos_q;
  logic [7:0]          byte_q;
  logic [AW-1:0]       ridx_q;
  logic [AW:0]         rcnt_q;
  logic [AW-1:0]       head_q;
  logic [31:0]         start_q;
  logic [RW:0]         v_q;
  logic                found_q;
  logic [AW:0]         len_q;
  logic [AW-1:0]       sidx_q;
  logic [7:0]          rdat_q;
  logic [ROW_BITS-1:0] row_q;
  logic [7:0]          dq_q;

  logic [31:0]         rel;
  logic                in_win;
  logic [AW-1:0]       slot;
  logic [RW-1:0]       slot_row;
  logic [ROW_LOG-1:0]  slot_bit;
  logic [RW-1:0]       vrow;
  logic [ROW_LOG-1:0]  off;
  logic                v_first, v_last;
  logic [AW:0]         rcnt_sat;
  logic [AW+1:0]       rm_lim;
  logic [ROW_BITS-1:0] mask, m, clr, rm_row, shm, set_row;
  logic [ROW_LOG:0]    b, t_find, t_run;
  logic                has, reach_end, scan_stop;
  logic [AW:0]         sidx_full;

  assign rel      = pos_q - start_q;
  assign in_win   = rel < 32'(WINDOW_BYTES);
  assign slot     = (cmd_q == CMD_WRITE) ? head_q + rel[AW-1:0] : head_q + ridx_q;
  assign slot_row = slot[AW-1:ROW_LOG];
  assign slot_bit = slot[ROW_LOG-1:0];
  assign off      = head_q[ROW_LOG-1:0];
  assign vrow     = head_q[AW-1:ROW_LOG] + v_q[RW-1:0];
  assign v_first  = (v_q == '0);
  assign v_last   = (v_q == (RW+1)'(ROWS));
  assign rcnt_sat = (rcnt_q > (AW+1)'(WINDOW_BYTES)) ? (AW+1)'(WINDOW_BYTES) : rcnt_q;
  assign rm_lim   = (AW+2)'(rcnt_sat) + (AW+2)'(off);
  assign set_row  = row_q | (ROW_BITS'(1) << slot_bit);

  always_comb begin
    for (int j = 0; j < ROW_BITS; j++) begin
      if (v_first) begin
        mask[j] = (ROW_LOG'(j) >= off);
      end else if (v_last) begin
        mask[j] = (ROW_LOG'(j) < off);
      end else begin
        mask[j] = 1'b1;
      end
      clr[j] = mask[j] && ((AW+2)'({v_q, ROW_LOG'(j)}) < rm_lim);
    end
  end

  assign m         = row_q & mask;
  assign rm_row    = row_q & ~clr;
  assign has       = (m != '0);
  assign b         = lowest_one({1'b0, m});
  assign shm       = m >> b[ROW_LOG-1:0];
  assign t_find    = lowest_one({1'b1, ~shm});
  assign t_run     = lowest_one({1'b1, ~m});
  assign reach_end = ((b + t_find) == (ROW_LOG+1)'(ROW_BITS));
  assign sidx_full = (AW+1)'({v_q, b[ROW_LOG-1:0]}) - (AW+1)'(off);
  assign scan_stop = v_last ||
                     (found_q ? (t_run != (ROW_LOG+1)'(ROW_BITS)) : (has && !reach_end));

  assign stat_o.cmd         = cmd_q;
  assign stat_o.in_win      = in_win;
  assign stat_o.scan_stop   = scan_stop;
  assign stat_o.v_last      = v_last;
  assign stat_o.v_init_last = (v_q == (RW+1)'(ROWS - 1));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= in_cmd_i;
      pos_q  <= in_pos_i;
      byte_q <= in_byte_i;
      ridx_q <= in_ridx_i;
      rcnt_q <= in_rcnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_SLOT) begin
      dq_q <= dmem[slot];
      if (cmd_q == CMD_WRITE) begin
        dmem[slot] <= byte_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_SLOT:        row_q <= fmem[slot_row];
      OP_RRD, OP_SRD: row_q <= fmem[vrow];
      default:        row_q <= row_q;
    endcase
    case (ctrl_i.op)
      OP_CLR:  fmem[vrow] <= '0;
      OP_SET:  fmem[slot_row] <= set_row;
      OP_RWR:  fmem[vrow] <= rm_row;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      start_q <= '0;
      v_q     <= '0;
      found_q <= 1'b0;
      len_q   <= '0;
      sidx_q  <= '0;
      rdat_q  <= '0;
    end else begin
      if (ctrl_i.load) rdat_q <= '0;
      case (ctrl_i.op)
        OP_CLR, OP_RWR: v_q <= v_q + (RW+1)'(1);
        OP_RDAT: rdat_q <= row_q[slot_bit] ? dq_q : 8'd0;
        OP_RFIN: begin
          head_q  <= head_q + rcnt_sat[AW-1:0];
          start_q <= start_q + 32'(rcnt_sat);
        end
        OP_SINIT: begin
          v_q     <= '0;
          found_q <= 1'b0;
          len_q   <= '0;
          sidx_q  <= '0;
        end
        OP_SEV: begin
          v_q <= v_q + (RW+1)'(1);
          if (!found_q && has) begin
            found_q <= 1'b1;
            sidx_q  <= sidx_full[AW-1:0];
            len_q   <= (AW+1)'(t_find);
          end else if (found_q) begin
            len_q <= len_q + (AW+1)'(t_run);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_OUT) begin
      out_rdata_o <= rdat_q;
      out_off_o   <= found_q ? start_q + 32'(sidx_q) : start_q;
      out_len_o   <= len_q;
      out_drop_o  <= (cmd_q == CMD_WRITE) && !in_win;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/stream_reassembly_buffer.sv
// Top level of the stream reassembly buffer: stream ports, controller and
// datapath. Depends on srb_pkg, srb_ctrl and srb_dpath.
//
// One request enters on the slave stream: a write stores a byte at an
// absolute stream position, a read returns the byte at a window index, a
// remove drops bytes from the head of the window. Every request gives exactly
// one result on the master stream: read byte, start and length of the first
// filled run, and a drop flag for writes outside the window.
// The filled map is kept in rows of 8 bits, R = WINDOW_BYTES / 8 rows. The
// run scan walks k rows from the head, reading and then evaluating each row,
// k from 1 to R + 1, and stops at the end of the first run. A dropped write
// or an undefined command goes straight to the scan; a write first sets its
// bit in the map and a read first fetches its byte; a remove first rewrites
// all R + 1 row visits and moves the head before the scan. The next request
// is accepted from the cycle after the result is loaded. After reset the
// block clears the filled map, one row a cycle, with tready low. Results sit
// in an output register; while the receiver stalls, the next request is
// accepted and worked on, and it waits only to load its own result until
// the register is free.
`default_nettype none

module stream_reassembly_buffer #(
  parameter int unsigned WINDOW_BYTES = 1024,
  localparam int unsigned AW = $clog2(WINDOW_BYTES),
  localparam int unsigned IN_W = ((41 + 2 * AW) + 7) / 8 * 8,
  localparam int unsigned OUT_W = ((41 + AW) + 7) / 8 * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // stream_pos[31:0], data_byte[7:0], read_index, remove_count, zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]       s_axis_tuser,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // read_data[7:0], run_offset[31:0], run_length, zero fill
  output logic [OUT_W-1:0] m_axis_tdata,
  // dropped
  output logic [0:0]       m_axis_tuser
);
  import srb_pkg::*;

  ctrl_t         ctrl;
  stat_t         stat;
  logic [7:0]    rdata;
  logic [31:0]   roff;
  logic [AW:0]   rlen;
  logic          drop;

  srb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  srb_dpath #(.WINDOW_BYTES(WINDOW_BYTES)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_cmd_i    (s_axis_tuser),
    .in_pos_i    (s_axis_tdata[31:0]),
    .in_byte_i   (s_axis_tdata[39:32]),
    .in_ridx_i   (s_axis_tdata[40 +: AW]),
    .in_rcnt_i   (s_axis_tdata[40 + AW +: AW + 1]),
    .out_rdata_o (rdata),
    .out_off_o   (roff),
    .out_len_o   (rlen),
    .out_drop_o  (drop)
  );

  assign m_axis_tdata = OUT_W'({rlen, roff, rdata});
  assign m_axis_tuser = drop;

endmodule

`default_nettype wire

// File: hw/rtl/srb_checker.sv
// Port-level checker of the stream reassembly buffer, bound to the top level.
// Depends on stream_reassembly_buffer_macros.svh.
`default_nettype none
`include "stream_reassembly_buffer_macros.svh"

module srb_checker #(
  parameter int unsigned WINDOW_BYTES = 1024,
  localparam int unsigned AW = $clog2(WINDOW_BYTES),
  localparam int unsigned OUT_W = ((41 + AW) + 7) / 8 * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [0:0]       m_axis_tuser
);

  logic [AW:0] out_len;

  assign out_len = m_axis_tdata[40 +: AW + 1];

  `SRB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SRB_ASSERT_IMP(a_len_max, clk_i, rst_ni, m_axis_tvalid, out_len <= (AW+1)'(WINDOW_BYTES))
  `SRB_ASSERT_IMP(a_drop_nodata, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[7:0] == 8'd0)
  `SRB_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind stream_reassembly_buffer srb_checker #(.WINDOW_BYTES(WINDOW_BYTES)) u_srb_checker (.*);

`default_nettype wire
